[rtl/lta_pkg.sv]
// Shared types, widths and register indexes for the LoRa time-on-air block.
// No dependencies; every other file in rtl/ imports this package.
package lta_pkg;

    localparam int LEN_W       = 8;   // payload length
    localparam int AIR_W       = 32;  // airtime in us
    localparam int PSYM_W      = 11;  // symbols after the preamble
    localparam int PRE_W       = 16;  // preamble length register
    localparam int SF_W        = 4;
    localparam int BW_W        = 2;
    localparam int CR_W        = 3;
    localparam int SH_W        = 4;   // left shift applied to the quarter-symbol count
    localparam int NUM_W       = 11;  // signed quarter numerator
    localparam int X_W         = 10;  // biased numerator for the ceiling divide
    localparam int Q_W         = 7;   // quotient (payload blocks)
    localparam int RCP_W       = 14;  // reciprocal of the divisor
    localparam int RCP_SHIFT   = 16;  // reciprocal scale 2^16
    localparam int PROD_W      = X_W + RCP_W;
    localparam int T_W         = 19;  // quarter-symbol count
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 48;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SF_W-1:0] SF_MIN = 4'd6;
    localparam logic [SF_W-1:0] SF_MAX = 4'd12;
    localparam logic [SF_W-1:0] SF_LDR = 4'd11;  // low-data-rate optimization from here up

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SF       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BW       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CR       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PREAMBLE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_IMPLICIT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CRC      = 3'd5;

    // Bandwidth select codes
    localparam logic [BW_W-1:0] BW_125 = 2'd0;
    localparam logic [BW_W-1:0] BW_250 = 2'd1;

    // Settings decoded once from the registers and shared by the pipeline
    typedef struct packed {
        logic [SF_W-1:0]  sf;       // clamped to 6..12
        logic [SF_W-1:0]  div;      // sf - 2*de, 6..10
        logic [RCP_W-1:0] rcp;      // floor(2^16 / div)
        logic [CR_W-1:0]  cr;
        logic [PRE_W-1:0] preamble;
        logic [SH_W-1:0]  sh;       // log2(tsym) - 2
        logic             implicit_hdr;
        logic             crc_on;
    } lta_cfg_t;

    function automatic logic [RCP_W-1:0] lta_recip(input logic [SF_W-1:0] div);
        logic [RCP_W-1:0] r;
        unique case (div)
            4'd6:    r = 14'd10922;
            4'd7:    r = 14'd9362;
            4'd8:    r = 14'd8192;
            4'd9:    r = 14'd7281;
            4'd10:   r = 14'd6553;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/lta_blocks.sv]
// Three-stage ceiling divide: payload blocks = ceil(num / den) clamped at zero.
// Uses a reciprocal multiply with one correction step. Depends on lta_pkg.
module lta_blocks
    import lta_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  lta_cfg_t         cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [LEN_W-1:0] in_len,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [Q_W-1:0]   out_blocks
);

    logic             v1_reg, v2_reg, v3_reg;
    logic             rdy1, rdy2, rdy3;
    logic [X_W-1:0]   x1_reg, x2_reg;
    logic [X_W-1:0]   x_next;
    logic [Q_W-1:0]   q2_reg, q2_next;
    logic [Q_W-1:0]   blk3_reg, blk3_next;
    logic [NUM_W-1:0] num;
    logic             num_pos;
    logic [PROD_W-1:0] prod;
    logic [X_W-1:0]   qd;
    logic [X_W-1:0]   rem;

    assign rdy3 = !v3_reg || out_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: numerator divided by four (all its terms are multiples of four),
    // biased by div - 1 for the ceiling
    always_comb begin
        num = (NUM_W'(in_len) << 1) + NUM_W'(7) + (cfg.crc_on ? NUM_W'(4) : NUM_W'(0))
            - NUM_W'(cfg.sf) - (cfg.implicit_hdr ? NUM_W'(5) : NUM_W'(0));
        num_pos = !num[NUM_W-1] && (num != '0);
        x_next  = num_pos ? X_W'(num + NUM_W'(cfg.div) - NUM_W'(1)) : '0;
    end

    // Stage 2: estimate, low by at most one
    always_comb begin
        prod    = PROD_W'(x1_reg) * PROD_W'(cfg.rcp);
        q2_next = prod[RCP_SHIFT +: Q_W];
    end

    // Stage 3: correct the estimate
    always_comb begin
        qd  = X_W'(q2_reg) * X_W'(cfg.div);
        rem = x2_reg - qd;
        blk3_next = (rem >= X_W'(cfg.div)) ? q2_reg + Q_W'(1) : q2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) x1_reg <= x_next;
        if (rdy2 && v1_reg) begin
            q2_reg <= q2_next;
            x2_reg <= x1_reg;
        end
        if (rdy3 && v2_reg) blk3_reg <= blk3_next;
    end

    assign out_valid  = v3_reg;
    assign out_blocks = blk3_reg;

endmodule

[rtl/lta_airtime.sv]
// Two-stage back end: payload symbol count, then airtime by symbol-time shift.
// The second stage is the output register. Depends on lta_pkg.
module lta_airtime
    import lta_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  lta_cfg_t          cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [Q_W-1:0]    in_blocks,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [AIR_W-1:0]  out_airtime,
    output logic [PSYM_W-1:0] out_psym
);

    logic              v4_reg, v5_reg;
    logic              rdy4, rdy5;
    logic [CR_W:0]     cr_mult;
    logic [PSYM_W-1:0] psym4_reg, psym4_next;
    logic [PSYM_W-1:0] psym5_reg;
    logic [T_W-1:0]    quarters;
    logic [AIR_W-1:0]  air5_reg, air5_next;

    assign rdy5 = !v5_reg || out_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign in_ready = rdy4;

    always_comb begin
        cr_mult    = {1'b0, cfg.cr} + (CR_W+1)'(4);
        psym4_next = PSYM_W'(in_blocks) * PSYM_W'(cr_mult) + PSYM_W'(8);
    end

    // Quarter symbols: 4*preamble + 17 + 4*psym, then times tsym / 4
    always_comb begin
        quarters  = T_W'({cfg.preamble, 2'b00}) + T_W'(17) + T_W'({psym4_reg, 2'b00});
        air5_next = AIR_W'(quarters) << cfg.sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy4) v4_reg <= in_valid;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && in_valid) psym4_reg <= psym4_next;
        if (rdy5 && v4_reg) begin
            air5_reg  <= air5_next;
            psym5_reg <= psym4_reg;
        end
    end

    assign out_valid   = v5_reg;
    assign out_airtime = air5_reg;
    assign out_psym    = psym5_reg;

endmodule

[rtl/lora_time_on_air_top.sv]
// Top level of the LoRa time-on-air calculator: config registers and stream ports.
// Instantiates lta_blocks and lta_airtime; depends on lta_pkg.
//
//  channel  | direction | word contents (low bit first)
//  s_axis   | in        | tdata[7:0] payload_length
//  m_axis   | out       | tdata[31:0] airtime_us, tdata[42:32] payload_symbols
//  cfg      | in        | cfg_addr selects register, cfg_wdata value, cfg_we strobe
//
// One word is accepted every cycle while m_tready stays high.
// The five stages are: numerator, reciprocal multiply, divide correction,
// symbol count multiply, and airtime shift into the output register.
// Each stage holds its word while the stage after it is full, so stalls lose nothing.
// aresetn (synchronous) empties the pipeline and restores the register defaults.
module lora_time_on_air_top
    import lta_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] payload_length
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [31:0] airtime_us, [42:32] payload_symbols
);

    logic [SF_W-1:0]  sf_reg;
    logic [BW_W-1:0]  bw_reg;
    logic [CR_W-1:0]  cr_reg;
    logic [PRE_W-1:0] pre_reg;
    logic             ih_reg;
    logic             crc_reg;

    lta_cfg_t         cfg;
    logic [SF_W-1:0]  sf_clamped;
    logic [SH_W-1:0]  bw_shift;

    logic             blk_valid, blk_ready;
    logic [Q_W-1:0]   blk_count;
    logic [AIR_W-1:0] airtime;
    logic [PSYM_W-1:0] psym;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sf_reg  <= 4'd10;
            bw_reg  <= BW_125;
            cr_reg  <= 3'd1;
            pre_reg <= 16'd8;
            ih_reg  <= 1'b0;
            crc_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SF:       sf_reg  <= cfg_wdata[SF_W-1:0];
                REG_BW:       bw_reg  <= cfg_wdata[BW_W-1:0];
                REG_CR:       cr_reg  <= cfg_wdata[CR_W-1:0];
                REG_PREAMBLE: pre_reg <= cfg_wdata[PRE_W-1:0];
                REG_IMPLICIT: ih_reg  <= cfg_wdata[0];
                REG_CRC:      crc_reg <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // Decode settings; symbol time is 2^sf * (8, 4 or 2) us
    always_comb begin
        priority if (sf_reg < SF_MIN) sf_clamped = SF_MIN;
        else if (sf_reg > SF_MAX)     sf_clamped = SF_MAX;
        else                          sf_clamped = sf_reg;

        unique case (bw_reg)
            BW_125:  bw_shift = SH_W'(3);
            BW_250:  bw_shift = SH_W'(2);
            default: bw_shift = SH_W'(1);
        endcase

        cfg.sf           = sf_clamped;
        cfg.div          = (sf_clamped >= SF_LDR) ? sf_clamped - SF_W'(2) : sf_clamped;
        cfg.rcp          = lta_recip(cfg.div);
        cfg.cr           = cr_reg;
        cfg.preamble     = pre_reg;
        cfg.sh           = sf_clamped + bw_shift - SH_W'(2);
        cfg.implicit_hdr = ih_reg;
        cfg.crc_on       = crc_reg;
    end

    lta_blocks u_blocks (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_len     (s_tdata[LEN_W-1:0]),
        .out_valid  (blk_valid),
        .out_ready  (blk_ready),
        .out_blocks (blk_count)
    );

    lta_airtime u_airtime (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (blk_valid),
        .in_ready    (blk_ready),
        .in_blocks   (blk_count),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_airtime (airtime),
        .out_psym    (psym)
    );

    assign m_tdata = {(M_TDATA_W-AIR_W-PSYM_W)'(0), psym, airtime};

`ifndef SYNTHESIS
    // The fixed eight-symbol term always leaves at least eight payload symbols
    a_psym_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[42:32] >= 11'd8))
        else $error("payload symbol count below eight");

    // Largest case is 86 blocks at coding rate 7
    a_psym_ceiling: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[42:32] <= 11'd954))
        else $error("payload symbol count above maximum");

    // Quarter-symbol count is odd and shifted by at least five
    a_air_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[31:0] != 32'd0) && (m_tdata[4:0] == 5'd0)))
        else $error("airtime not a nonzero multiple of the minimum symbol quarter");
`endif

endmodule

[tb/sv/tb_lora_time_on_air_top.sv]
// Self-checking bench for lora_time_on_air_top: payload lengths in, airtime and symbol count out.
// Predicts every word with its own airtime calculation; depends on lta_pkg and the RTL only.
module tb_lora_time_on_air_top
    import lta_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;  // no register behind these
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int LONG_HOLD     = 250;
    localparam int LONG_HOLD_AT  = 150;   // output words seen before the long hold starts
    localparam int DRAIN_CYCLES  = 8;     // pipeline is five deep
    localparam int STUCK_LIMIT   = 2000;

    typedef struct packed {
        logic [SF_W-1:0]  sf;
        logic [BW_W-1:0]  bw;
        logic [CR_W-1:0]  cr;
        logic [PRE_W-1:0] preamble;
        logic             implicit_hdr;
        logic             crc_on;
    } radio_cfg_t;

    typedef struct packed {
        logic [PSYM_W-1:0] psym;
        logic [AIR_W-1:0]  air_us;
    } toa_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] payload_length
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [31:0] airtime_us, [42:32] payload_symbols

    radio_cfg_t           radio = '{sf: 4'd10, bw: 2'd0, cr: 3'd1, preamble: 16'd8,
                                    implicit_hdr: 1'b0, crc_on: 1'b1};
    logic [LEN_W-1:0]     pending_len[$];
    toa_t                 expected_toa[$];
    bit                   word_held      = 1'b0;
    bit                   steady_tail    = 1'b0;
    bit                   long_hold_done = 1'b0;
    int                   src_wait       = 0;
    int                   sink_wait      = 0;
    int                   words_out      = 0;
    int                   mismatches     = 0;
    int                   stuck_cycles   = 0;

    lora_time_on_air_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Airtime in quarter microseconds keeps the 4.25-symbol preamble tail exact.
    function automatic toa_t time_on_air(input radio_cfg_t c, input logic [LEN_W-1:0] len);
        longint unsigned sf;
        longint unsigned chip_us;
        longint unsigned tsym;
        longint unsigned ldr;
        longint          num;
        longint          den;
        longint unsigned blocks;
        longint unsigned sym_count;
        longint unsigned quarters;
        toa_t            r;
        sf = c.sf;
        if (sf < SF_MIN) sf = SF_MIN;
        if (sf > SF_MAX) sf = SF_MAX;
        if (c.bw == BW_125)      chip_us = 8;
        else if (c.bw == BW_250) chip_us = 4;
        else                     chip_us = 2;
        tsym = (64'd1 << sf) * chip_us;
        ldr  = (sf >= SF_LDR) ? 1 : 0;
        num  = 8 * longint'(len) - 4 * longint'(sf) + 28
             + 16 * longint'(c.crc_on) - 20 * longint'(c.implicit_hdr);
        den  = 4 * (longint'(sf) - 2 * longint'(ldr));
        blocks = (num > 0) ? longint'((num + den - 1) / den) : 0;
        sym_count = 8 + blocks * (longint'(c.cr) + 4);
        quarters  = (4 * longint'(c.preamble) + 17 + 4 * sym_count) * tsym;
        r.air_us = quarters[AIR_W+1:2];
        r.psym   = sym_count[PSYM_W-1:0];
        return r;
    endfunction

    function automatic radio_cfg_t make_cfg(input int sf, input int bw, input int cr,
                                            input int pre, input bit ih, input bit crc);
        radio_cfg_t c;
        c.sf           = sf[SF_W-1:0];
        c.bw           = bw[BW_W-1:0];
        c.cr           = cr[CR_W-1:0];
        c.preamble     = pre[PRE_W-1:0];
        c.implicit_hdr = ih;
        c.crc_on       = crc;
        return c;
    endfunction

    function automatic radio_cfg_t random_cfg();
        radio_cfg_t c;
        c.sf = ($urandom_range(0, 7) == 0) ? SF_W'($urandom_range(0, 15))
                                           : SF_W'($urandom_range(6, 12));
        c.bw = BW_W'($urandom_range(0, 3));
        c.cr = ($urandom_range(0, 5) == 0) ? CR_W'($urandom_range(0, 7))
                                           : CR_W'($urandom_range(1, 4));
        case ($urandom_range(0, 7))
            0:       c.preamble = PRE_W'($urandom_range(0, 5));
            1:       c.preamble = 16'hFFFF;
            2, 3, 4: c.preamble = PRE_W'($urandom_range(6, 64));
            default: c.preamble = PRE_W'($urandom_range(6, 65535));
        endcase
        c.implicit_hdr = 1'($urandom_range(0, 1));
        c.crc_on       = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return LEN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Drive one register write; the shadow copy keeps only the bits the register holds.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_SF:       radio.sf           = value[SF_W-1:0];
            REG_BW:       radio.bw           = value[BW_W-1:0];
            REG_CR:       radio.cr           = value[CR_W-1:0];
            REG_PREAMBLE: radio.preamble     = value[PRE_W-1:0];
            REG_IMPLICIT: radio.implicit_hdr = value[0];
            REG_CRC:      radio.crc_on       = value[0];
            default: ;
        endcase
    endtask

    // Junk in the unused upper bits must be ignored by the block.
    task automatic apply_cfg(input radio_cfg_t c);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_SF,       {junk[15:4], c.sf});
        write_reg(REG_BW,       {junk[13:0], c.bw});
        write_reg(REG_CR,       {junk[12:0], c.cr});
        write_reg(REG_PREAMBLE, c.preamble);
        write_reg(REG_IMPLICIT, {junk[15:1], c.implicit_hdr});
        write_reg(REG_CRC,      {~junk[15:1], c.crc_on});
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_len.size() != 0 || word_held || expected_toa.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic note_mismatch(input string what, input toa_t want, input logic [M_TDATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): expected air %0d psym %0d, got air %0d psym %0d",
                     $realtime, what, want.air_us, want.psym, got[31:0], got[42:32]);
    endtask

    // Source side: present queued lengths, with random gaps between words until steady_tail is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_toa.push_back(time_on_air(radio, s_tdata));
                word_held = 1'b0;
            end
            if (!word_held) begin
                if (src_wait == 0 && !steady_tail && $urandom_range(0, 7) == 0)
                    src_wait = $urandom_range(1, 15);
                if (src_wait > 0) begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_len.size() != 0) begin
                    s_tdata   <= pending_len.pop_front();
                    s_tvalid  <= 1'b1;
                    word_held = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: check each output word against the oldest prediction, stall at random until steady_tail is set.
    always @(posedge aclk) begin
        toa_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_out++;
                if (expected_toa.size() == 0) begin
                    note_mismatch("no word expected", '0, m_tdata);
                end else begin
                    want = expected_toa.pop_front();
                    if (m_tdata[31:0] !== want.air_us || m_tdata[42:32] !== want.psym)
                        note_mismatch("field", want, m_tdata);
                end
            end
            // Hold off long enough to back the pipeline up into the input.
            if (!long_hold_done && words_out >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                sink_wait = LONG_HOLD;
            end else if (sink_wait == 0 && !steady_tail && $urandom_range(0, 7) == 0) begin
                sink_wait = $urandom_range(1, 15);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        radio_cfg_t c;
        int n;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults straight out of reset.
        pending_len.push_back(8'd0);
        pending_len.push_back(8'd255);
        pending_len.push_back(8'd1);
        pending_len.push_back(8'd128);
        pending_len.push_back(8'd85);
        wait_drained();

        // Writes to unused indexes must not disturb anything.
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'hA5A5);
        // Top spreading factor with low-data-rate, longest preamble; empty payload goes negative.
        apply_cfg(make_cfg(12, 2, 4, 65535, 1'b1, 1'b0));
        pending_len.push_back(8'd0);
        pending_len.push_back(8'd3);
        pending_len.push_back(8'd255);
        wait_drained();

        // Smallest spreading factor, coding rate zero, zero preamble.
        apply_cfg(make_cfg(6, 1, 0, 0, 1'b0, 1'b1));
        pending_len.push_back(8'd0);
        pending_len.push_back(8'd255);
        pending_len.push_back(8'd170);
        wait_drained();

        // Spreading factor above range, bandwidth code 3, largest coding rate.
        apply_cfg(make_cfg(15, 3, 7, 6, 1'b0, 1'b0));
        pending_len.push_back(8'd0);
        pending_len.push_back(8'd255);
        wait_drained();

        // Spreading factor below range.
        apply_cfg(make_cfg(0, 0, 5, 40, 1'b1, 1'b1));
        pending_len.push_back(8'd0);
        pending_len.push_back(8'd255);
        wait_drained();

        apply_cfg(make_cfg(5, 2, 6, 12, 1'b0, 1'b1));
        pending_len.push_back(8'd77);
        wait_drained();

        apply_cfg(make_cfg(13, 1, 3, 300, 1'b1, 1'b0));
        pending_len.push_back(8'd200);
        wait_drained();

        // First spreading factor with low-data-rate optimization.
        apply_cfg(make_cfg(11, 1, 2, 8, 1'b0, 1'b1));
        pending_len.push_back(8'd0);
        pending_len.push_back(8'd255);
        pending_len.push_back(8'd51);
        wait_drained();

        for (int k = 0; k < 12; k++) begin
            if (k == 1)      c = make_cfg(6, 0, 1, 6, 1'b1, 1'b0);
            else if (k == 2) c = make_cfg(12, 2, 4, 65535, 1'b0, 1'b1);
            else             c = random_cfg();
            if (k == 10) steady_tail = 1'b1;
            apply_cfg(c);
            n = (k == 0) ? 400 : 100;
            repeat (n) pending_len.push_back(pick_length());
            wait_drained();
        end

        if (mismatches == 0 && expected_toa.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/lta_pkg.sv
rtl/lta_blocks.sv
rtl/lta_airtime.sv
rtl/lora_time_on_air_top.sv
tb/sv/tb_lora_time_on_air_top.sv
